@@ hdl/autorange_temp_sensor_convert_top_defines.svh @@
// Assertion macros shared by the checker of the auto-ranging sensor converter.
// Each macro expects a signal named clk, and all but ATSC_ASSERT_RST one named rst_n, in the scope where it is used.
`ifndef AUTORANGE_TEMP_SENSOR_CONVERT_TOP_DEFINES_SVH
`define AUTORANGE_TEMP_SENSOR_CONVERT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATSC_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATSC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define ATSC_ASSERT_RST(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/atsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsc_pkg: shared types and constants of the sensor converter
// Level table, action codes and the result record passed to the top level.
// ----------------------------------------------------------------------------
package atsc_pkg;

  typedef logic [2:0]         level_t;
  typedef logic signed [19:0] wide_t;
  typedef logic signed [18:0] celsius_t;

  localparam level_t LEVEL_MAX   = 3'd4;
  localparam level_t LEVEL_RESET = 3'd2;

  // Q.10 scaling constants.
  localparam wide_t ADC_GAIN_Q10   = 20'sd449;
  localparam wide_t SYS_OFFSET_Q10 = 20'sd21012;
  localparam wide_t Q_ONE          = 20'sd1024;
  localparam wide_t BYTE_SAT_Q10   = 20'sd262144;

  typedef enum logic [2:0] {
    ACT_IN_RANGE   = 3'd0,
    ACT_UP         = 3'd1,
    ACT_LOW_LIMIT  = 3'd2,
    ACT_DOWN       = 3'd3,
    ACT_HIGH_LIMIT = 3'd4
  } action_t;

  typedef struct packed {
    celsius_t   celsius_q10;
    logic [7:0] temp_byte;
    level_t     level_used;
    level_t     next_level;
    action_t    range_action;
  } result_t;

  // DAC offset contribution, -28549 * offset[level]. Codes above 4 act as 4.
  function automatic wide_t dac_term(input level_t lvl);
    wide_t t;
    unique case (lvl)
      3'd0:    t = 20'sd57098;
      3'd1:    t = 20'sd28549;
      3'd2:    t = 20'sd0;
      3'd3:    t = -20'sd28549;
      default: t = -20'sd57098;
    endcase
    return t;
  endfunction

  function automatic wide_t min_q10(input level_t lvl);
    wide_t t;
    unique case (lvl)
      3'd0:    t = 20'sd51200;
      3'd1:    t = 20'sd20480;
      3'd2:    t = -20'sd10240;
      3'd3:    t = -20'sd30720;
      default: t = -20'sd40960;
    endcase
    return t;
  endfunction

  function automatic wide_t max_q10(input level_t lvl);
    wide_t t;
    unique case (lvl)
      3'd0:    t = 20'sd128000;
      3'd1:    t = 20'sd102400;
      3'd2:    t = 20'sd81920;
      3'd3:    t = 20'sd51200;
      default: t = 20'sd20480;
    endcase
    return t;
  endfunction

endpackage

@@ hdl/atsc_cal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsc_cal: calibration register
// Holds the trim in tenths of a degree and its Q.10 form, trunc(d*1024/10).
// ----------------------------------------------------------------------------
module atsc_cal (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [10:0]            cfg_wdata,
  output logic signed [18:0]     corr_q10
);

  logic signed [10:0] delta_r;
  logic signed [18:0] corr_r, corr_nxt;

  logic        neg;
  logic [10:0] mag;
  logic [26:0] prod;
  logic [7:0]  quo;
  logic [10:0] rem_full;
  logic [8:0]  frac;
  logic [17:0] mag_corr;

  // Fraction of 512/5 for each remainder of the division by five.
  function automatic logic [8:0] frac_of(input logic [2:0] r);
    logic [8:0] f;
    unique case (r)
      3'd0:    f = 9'd0;
      3'd1:    f = 9'd102;
      3'd2:    f = 9'd204;
      3'd3:    f = 9'd307;
      default: f = 9'd409;
    endcase
    return f;
  endfunction

  always_comb begin
    neg      = delta_r[10];
    mag      = neg ? 11'(-delta_r) : 11'(delta_r);
    // Divide by five with a reciprocal; exact for every magnitude up to 1024.
    prod     = 27'(mag) * 27'd52429;
    quo      = prod[25:18];
    rem_full = mag - 11'(quo) * 11'd5;
    frac     = frac_of(rem_full[2:0]);
    mag_corr = {1'b0, quo, 9'b0} + 18'(frac);
    corr_nxt = neg ? -$signed({1'b0, mag_corr}) : $signed({1'b0, mag_corr});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= '0;
      corr_r  <= '0;
    end else begin
      if (cfg_we) begin
        delta_r <= $signed(cfg_wdata);
      end
      corr_r <= corr_nxt;
    end
  end

  assign corr_q10 = corr_r;

endmodule

@@ hdl/atsc_conv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsc_conv: sample conversion and range decision
// Converts one raw code at the given level and picks the next level.
// ----------------------------------------------------------------------------
module atsc_conv (
  input  logic [7:0]          raw_sample,
  input  atsc_pkg::level_t    level,
  input  logic signed [18:0]  corr_q10,
  output atsc_pkg::result_t   result
);

  atsc_pkg::wide_t  q;
  atsc_pkg::level_t lvl;
  logic [7:0]       tb;

  always_comb begin
    lvl = (level > atsc_pkg::LEVEL_MAX) ? atsc_pkg::LEVEL_MAX : level;
    q   = atsc_pkg::wide_t'({12'b0, raw_sample}) * atsc_pkg::ADC_GAIN_Q10
          + atsc_pkg::dac_term(lvl) - atsc_pkg::SYS_OFFSET_Q10
          - atsc_pkg::wide_t'(corr_q10);

    if (q <= atsc_pkg::Q_ONE) begin
      tb = 8'd1;
    end else if (q >= atsc_pkg::BYTE_SAT_Q10) begin
      tb = 8'd255;
    end else begin
      tb = q[17:10];
    end

    result.celsius_q10 = q[18:0];
    result.temp_byte   = tb;
    result.level_used  = lvl;
    result.next_level  = lvl;
    result.range_action = atsc_pkg::ACT_IN_RANGE;

    if (q < atsc_pkg::min_q10(lvl)) begin
      if (lvl < atsc_pkg::LEVEL_MAX) begin
        result.next_level   = lvl + 3'd1;
        result.range_action = atsc_pkg::ACT_UP;
      end else begin
        result.range_action = atsc_pkg::ACT_LOW_LIMIT;
      end
    end else if (q > atsc_pkg::max_q10(lvl)) begin
      if (lvl != 3'd0) begin
        result.next_level   = lvl - 3'd1;
        result.range_action = atsc_pkg::ACT_DOWN;
      end else begin
        result.range_action = atsc_pkg::ACT_HIGH_LIMIT;
      end
    end
  end

endmodule

@@ hdl/autorange_temp_sensor_convert_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autorange_temp_sensor_convert_top: auto-ranging temperature sensor converter
// Converts raw sensor codes to Celsius and tracks the DAC range level.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one raw 8-bit sensor code per request. For each
//   one the out_ stream returns exactly one request with the Q.10 Celsius
//   value, a byte temperature, the level applied, the next level and the
//   range action taken.
//   The cfg_ port writes the calibration trim (tenths of a degree); write it
//   only while no sample is in flight. Samples accepted from the cycle after
//   the write edge on use the new trim.
//   An accepted sample goes through the input register, then the conversion
//   into the result register, before out_tvalid rises for it.
//   Throughput is one sample per cycle while out_tready stays high; the range
//   level register is updated as each sample moves into the result register,
//   so the next sample sees the new level without a bubble.
//   When the receiver stalls, the result register holds and the input
//   register still accepts one more sample; after that in_tready drops.
//   Synchronous reset empties both registers, sets the level to 2 and the
//   trim to zero.
// ----------------------------------------------------------------------------
module autorange_temp_sensor_convert_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] raw_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  // [18:0] celsius_q10, [26:19] temp_byte, [29:27] level_used,
  // [32:30] next_level, [35:33] range_action, [39:36] zero
  output logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  logic               in_valid_r;
  logic [7:0]         raw_r;
  logic               out_valid_r;
  atsc_pkg::result_t  res_r;
  atsc_pkg::result_t  res_nxt;
  atsc_pkg::level_t   level_r;
  logic signed [18:0] corr_q10;
  logic               load_out;

  atsc_cal u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .corr_q10  (corr_q10)
  );

  atsc_conv u_conv (
    .raw_sample (raw_r),
    .level      (level_r),
    .corr_q10   (corr_q10),
    .result     (res_nxt)
  );

  assign load_out  = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      level_r     <= atsc_pkg::LEVEL_RESET;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        level_r     <= res_nxt.next_level;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      raw_r <= in_tdata;
    end
    if (load_out) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, res_r.range_action, res_r.next_level, res_r.level_used,
                       res_r.temp_byte, res_r.celsius_q10};

endmodule

@@ hdl/atsc_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsc_chk: port checker for the sensor converter
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
`include "autorange_temp_sensor_convert_top_defines.svh"

module atsc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  logic [2:0] used_f;
  logic [2:0] next_f;
  logic [2:0] act_f;

  assign used_f = out_tdata[29:27];
  assign next_f = out_tdata[32:30];
  assign act_f  = out_tdata[35:33];

  // A stalled result request must hold its contents.
  `ATSC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // The level only changes when the range action says it stepped.
  `ATSC_ASSERT_NOW(a_level_step, out_tvalid && (next_f != used_f), (act_f == atsc_pkg::ACT_UP && next_f == used_f + 3'd1) || (act_f == atsc_pkg::ACT_DOWN && next_f == used_f - 3'd1), "level moved without a step action")

  // The byte temperature is floored at one.
  `ATSC_ASSERT_NOW(a_byte_floor, out_tvalid, out_tdata[26:19] != 8'd0, "temp_byte is zero")

  // Nothing is offered right after reset.
  `ATSC_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind autorange_temp_sensor_convert_top atsc_chk u_atsc_chk (.*);
